@@ rtl/fssf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fssf_pkg;

  localparam int TRACK_BYTES_DEF  = 16384;
  localparam int MAX_SEGMENTS_DEF = 23;

  localparam logic [15:0] SYNC_WORD_RESET = 16'h4489;
  localparam logic [10:0] GCR_SYNC_VAL    = 11'b11111111110;

  localparam logic [1:0] KIND_LOSS = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_TERM = 2'd2;

  localparam logic CFG_GCR_MODE  = 1'b0;
  localparam logic CFG_SYNC_WORD = 1'b1;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [13:0] segment_start;
    logic [2:0]  bit_shift;
    logic [13:0] segment_length;
    logic [4:0]  segment_number;
    logic        table_overflow;
    logic        track_done;
  } out_beat_t;

  typedef struct packed {
    logic [16:0] hist;
    logic        in_sync;
    logic [2:0]  open_shift;
  } seq_t;

endpackage

`default_nettype wire

@@ rtl/fssf_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fssf_step
  import fssf_pkg::*;
#(
  parameter int TRACK_BYTES  = TRACK_BYTES_DEF,
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  localparam int PW = $clog2(TRACK_BYTES),
  localparam int CW = $clog2(MAX_SEGMENTS + 1)
) (
  input  wire  logic        gcr_mode,
  input  wire  logic [15:0] sync_word,
  input  wire  in_beat_t    beat,
  input  wire  seq_t        seq,
  input  wire  logic [PW-1:0] pos,
  input  wire  logic [PW-1:0] open_start,
  input  wire  logic [CW-1:0] seg_count,
  output seq_t              seq_next,
  output logic [PW-1:0]     pos_next,
  output logic [PW-1:0]     open_start_next,
  output logic [CW-1:0]     seg_count_next,
  output logic              emit,
  output out_beat_t         result
);

  logic [16:0]   hist;
  logic          sync;
  logic          stop;
  logic          lost;
  logic          found;
  logic [2:0]    found_shift;
  logic          segment;
  logic [PW-1:0] pos_inc;
  logic [PW-1:0] end_pos;
  logic [PW:0]   diff;
  logic [PW-1:0] len;
  logic [CW:0]   count_inc;

  always_comb begin
    hist        = seq.hist;
    sync        = seq.in_sync;
    stop        = 1'b0;
    lost        = 1'b0;
    found       = 1'b0;
    found_shift = seq.open_shift;
    for (int j = 0; j < 8; j++) begin
      if (seq.in_sync) begin
        if (!stop) begin
          hist = {hist[15:0], beat.raw_byte[7-j]};
          if (gcr_mode ? (hist[2:0] == 3'b000) : (hist[3:0] == 4'b0000)) begin
            stop = 1'b1;
            lost = 1'b1;
            sync = 1'b0;
          end
        end
      end else begin
        hist = {hist[15:0], beat.raw_byte[7-j]};
        if (gcr_mode ? (hist[10:0] == GCR_SYNC_VAL) : (hist == {sync_word, 1'b0})) begin
          found       = 1'b1;
          sync        = 1'b1;
          found_shift = 3'(j);
        end
      end
    end
  end

  assign pos_inc         = (pos == PW'(TRACK_BYTES - 1)) ? '0 : pos + 1'b1;
  assign open_start_next = found ? pos : open_start;
  assign end_pos         = lost ? pos : pos_inc;
  assign segment         = lost || (beat.last_byte && sync);
  assign emit            = lost || beat.last_byte;

  always_comb begin
    diff = {1'b0, end_pos} - {1'b0, open_start_next} - (PW+1)'(1);
    if (diff[PW]) begin
      diff = diff + (PW+1)'(TRACK_BYTES);
    end
    len = diff[PW-1:0];
    if (!gcr_mode) begin
      len[0] = 1'b0;
    end
  end

  assign count_inc = {1'b0, seg_count} + 1'b1;

  always_comb begin
    result.result_kind    = lost ? KIND_LOSS : (sync ? KIND_END : KIND_TERM);
    result.segment_start  = segment ? 14'(open_start_next) : '0;
    result.bit_shift      = segment ? found_shift : '0;
    result.segment_length = segment ? 14'(len) : '0;
    result.segment_number = 5'(seg_count);
    result.table_overflow = segment ? (count_inc >= (CW+1)'(MAX_SEGMENTS))
                                    : ({1'b0, seg_count} >= (CW+1)'(MAX_SEGMENTS));
    result.track_done     = beat.last_byte;
  end

  always_comb begin
    seq_next.open_shift = found_shift;
    if (beat.last_byte) begin
      seq_next.hist    = '0;
      seq_next.in_sync = 1'b0;
      pos_next         = '0;
      seg_count_next   = '0;
    end else begin
      seq_next.hist    = hist;
      seq_next.in_sync = sync;
      pos_next         = pos_inc;
      if (segment && ({1'b0, seg_count} < (CW+1)'(MAX_SEGMENTS))) begin
        seg_count_next = count_inc[CW-1:0];
      end else begin
        seg_count_next = seg_count;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/floppy_sync_segment_finder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  payload      handshake
// in        input      in_beat_t    in_valid / in_stall
// out       output     out_beat_t   out_valid / out_stall
// cfg       input      16-bit data  cfg_write / cfg_index
//
// one beat per cycle sustained unless a held result stalls input; a beat
// waits in the input register and leaves any result in the output register
// the bit scan of a byte is eight unrolled steps between those registers
// reset restores default configuration, clears search state and both valid flags
// a held result stalls input only when the next beat also has a result

module floppy_sync_segment_finder
  import fssf_pkg::*;
#(
  parameter int TRACK_BYTES  = TRACK_BYTES_DEF,
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        in_valid,
  output logic              in_stall,
  input  wire  in_beat_t    in_data,
  output logic              out_valid,
  input  wire  logic        out_stall,
  output out_beat_t         out_data,
  input  wire  logic        cfg_write,
  input  wire  logic        cfg_index,
  input  wire  logic [15:0] cfg_data
);

  localparam int PW = $clog2(TRACK_BYTES);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  logic          gcr_mode;
  logic [15:0]   sync_word;
  seq_t          seq;
  seq_t          seq_next;
  logic [PW-1:0] pos;
  logic [PW-1:0] pos_next;
  logic [PW-1:0] open_start;
  logic [PW-1:0] open_start_next;
  logic [CW-1:0] seg_count;
  logic [CW-1:0] seg_count_next;
  logic          hold_valid;
  in_beat_t      hold;
  logic          emit;
  out_beat_t     result;
  logic          advance;

  fssf_step #(
    .TRACK_BYTES  (TRACK_BYTES),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_step (
    .gcr_mode        (gcr_mode),
    .sync_word       (sync_word),
    .beat            (hold),
    .seq             (seq),
    .pos             (pos),
    .open_start      (open_start),
    .seg_count       (seg_count),
    .seq_next        (seq_next),
    .pos_next        (pos_next),
    .open_start_next (open_start_next),
    .seg_count_next  (seg_count_next),
    .emit            (emit),
    .result          (result)
  );

  assign advance  = hold_valid && (!emit || !out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      gcr_mode  <= 1'b0;
      sync_word <= SYNC_WORD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_GCR_MODE:  gcr_mode  <= cfg_data[0];
        CFG_SYNC_WORD: sync_word <= cfg_data;
        default:       gcr_mode  <= gcr_mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq        <= '0;
      pos        <= '0;
      open_start <= '0;
      seg_count  <= '0;
    end else if (advance) begin
      seq        <= seq_next;
      pos        <= pos_next;
      open_start <= open_start_next;
      seg_count  <= seg_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

@@ rtl/fssf_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fssf_checker
  import fssf_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire out_beat_t   out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");

  a_term_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == KIND_TERM |->
      out_data.track_done && out_data.segment_start == 14'd0 &&
      out_data.segment_length == 14'd0 && out_data.bit_shift == 3'd0)
    else $error("terminator beat carries segment fields");

  a_end_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == KIND_END |-> out_data.track_done)
    else $error("track end beat without track_done");

endmodule

bind floppy_sync_segment_finder fssf_checker u_fssf_checker (.*);

`default_nettype wire

@@ bench/fssf_track_checker.sv @@
`timescale 1ns / 1ps

module fssf_track_checker
  import fssf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire in_beat_t    in_data,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire out_beat_t   out_data,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               fail_count,
  output int               pending
);

  logic        gcr_mode;
  logic [15:0] sync_word;
  logic [16:0] history;
  logic        locked;
  logic [13:0] byte_pos;
  logic [13:0] seg_start;
  logic [2:0]  seg_shift;
  logic [4:0]  seg_count;
  out_beat_t   expected_table_entries[$];

  task automatic record_entry(input logic [1:0] kind, input logic has_seg,
                              input logic [13:0] end_pos, input logic done);
    out_beat_t   entry;
    logic [13:0] len;
    len = end_pos - seg_start - 14'd1;
    if (!gcr_mode) begin
      len[0] = 1'b0;
    end
    entry.result_kind    = kind;
    entry.segment_start  = has_seg ? seg_start : '0;
    entry.bit_shift      = has_seg ? seg_shift : '0;
    entry.segment_length = has_seg ? len : '0;
    entry.segment_number = seg_count;
    entry.table_overflow = has_seg ? (seg_count + 1 >= MAX_SEGMENTS_DEF)
                                   : (seg_count >= MAX_SEGMENTS_DEF);
    entry.track_done     = done;
    expected_table_entries.push_back(entry);
    if (has_seg && seg_count < MAX_SEGMENTS_DEF) begin
      seg_count = seg_count + 5'd1;
    end
  endtask

  task automatic scan_track_byte(input in_beat_t beat);
    logic [13:0] pos;
    logic        produced;
    logic        hit;
    pos = byte_pos;
    produced = 1'b0;
    if (locked) begin
      for (int j = 0; j < 8 && !produced; j++) begin
        history = {history[15:0], beat.raw_byte[7 - j]};
        if (gcr_mode ? history[2:0] == 3'b000 : history[3:0] == 4'b0000) begin
          locked = 1'b0;
          record_entry(KIND_LOSS, 1'b1, pos, beat.last_byte);
          produced = 1'b1;
        end
      end
    end else begin
      for (int j = 0; j < 8; j++) begin
        history = {history[15:0], beat.raw_byte[7 - j]};
        hit = gcr_mode ? history[10:0] == GCR_SYNC_VAL : history == {sync_word, 1'b0};
        if (hit) begin
          locked = 1'b1;
          seg_start = pos;
          seg_shift = 3'(j);
        end
      end
    end
    if (beat.last_byte) begin
      if (!produced) begin
        if (locked) begin
          record_entry(KIND_END, 1'b1, pos + 14'd1, 1'b1);
        end else begin
          record_entry(KIND_TERM, 1'b0, '0, 1'b1);
        end
      end
      history = '0;
      locked = 1'b0;
      byte_pos = '0;
      seg_count = '0;
    end else begin
      byte_pos = pos + 14'd1;
    end
  endtask

  task automatic report_mismatch(input string what, input out_beat_t want,
                                 input out_beat_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s: exp kind %0d start %0d shift %0d len %0d num %0d ovf %0d done %0d",
               $time, what, want.result_kind, want.segment_start, want.bit_shift,
               want.segment_length, want.segment_number, want.table_overflow,
               want.track_done);
      $display("%0t: %s: got kind %0d start %0d shift %0d len %0d num %0d ovf %0d done %0d",
               $time, what, got.result_kind, got.segment_start, got.bit_shift,
               got.segment_length, got.segment_number, got.table_overflow,
               got.track_done);
    end
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      gcr_mode = 1'b0;
      sync_word = SYNC_WORD_RESET;
      history = '0;
      locked = 1'b0;
      byte_pos = '0;
      seg_start = '0;
      seg_shift = '0;
      seg_count = '0;
      expected_table_entries.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_table_entries.size() == 0) begin
          report_mismatch("unexpected beat", '0, out_data);
        end else begin
          want = expected_table_entries.pop_front();
          if (want.result_kind !== out_data.result_kind ||
              want.segment_start !== out_data.segment_start ||
              want.bit_shift !== out_data.bit_shift ||
              want.segment_length !== out_data.segment_length ||
              want.segment_number !== out_data.segment_number ||
              want.table_overflow !== out_data.table_overflow ||
              want.track_done !== out_data.track_done) begin
            report_mismatch("mismatch", want, out_data);
          end
        end
      end
      if (in_valid && !in_stall) begin
        scan_track_byte(in_data);
      end
      if (cfg_write) begin
        if (cfg_index == CFG_GCR_MODE) begin
          gcr_mode = cfg_data[0];
        end else begin
          sync_word = cfg_data;
        end
      end
    end
    pending = expected_table_entries.size();
  end

endmodule

@@ bench/tb_floppy_sync_segment_finder.sv @@
`timescale 1ns / 1ps

module tb_floppy_sync_segment_finder;
  import fssf_pkg::*;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;
  logic        cfg_write = 1'b0;
  logic        cfg_index = CFG_GCR_MODE;
  logic [15:0] cfg_data = '0;

  int fail_count;
  int pending;

  logic        gcr_now = 1'b0;
  logic [15:0] sync_now = SYNC_WORD_RESET;
  logic        track_bits[$];
  int          items_sent;
  int          send_calm;
  int          pressure_asked;
  int          pressure_taken;
  int          hold_left;
  int          stall_left;
  int          recv_calm;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  floppy_sync_segment_finder i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  fssf_track_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // receiver: random stalls, calm stretches and the long hold-off on request
  always @(negedge clk) begin
    int unsigned pick;
    if (pressure_taken != pressure_asked) begin
      pressure_taken = pressure_asked;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (recv_calm > 0) begin
      recv_calm--;
      out_stall <= 1'b0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        recv_calm = $urandom_range(30, 80);
      end else if (pick >= 60 && pick < 95) begin
        stall_left = $urandom_range(1, 3);
      end else if (pick >= 95) begin
        stall_left = $urandom_range(10, 30);
      end
      out_stall <= 1'b0;
    end
  end

  function automatic int unsigned sender_gap();
    int unsigned pick;
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      send_calm = $urandom_range(20, 60);
    end
    if (pick < 55) begin
      return 0;
    end
    if (pick < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 30);
  endfunction

  task automatic send_beat(input logic [7:0] raw, input logic is_last);
    int unsigned gap;
    in_beat_t    beat;
    gap = sender_gap();
    beat.raw_byte = raw;
    beat.last_byte = is_last;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_GCR_MODE) begin
      gcr_now = value[0];
    end else begin
      sync_now = value;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic pick_settings();
    logic [15:0] word;
    case ($urandom_range(0, 7))
      0: word = 16'h0000;
      1: word = 16'hFFFF;
      2, 3: word = 16'($urandom);
      default: word = SYNC_WORD_RESET;
    endcase
    write_reg(CFG_GCR_MODE, 16'($urandom_range(0, 1)));
    write_reg(CFG_SYNC_WORD, word);
  endtask

  task automatic add_bits(input logic [31:0] value, input int n);
    for (int k = n - 1; k >= 0; k--) begin
      track_bits.push_back(value[k]);
    end
  endtask

  task automatic add_noise(input int n);
    repeat (n) track_bits.push_back(1'($urandom_range(0, 1)));
  endtask

  // run-limited data that stays in sync for the current mode
  task automatic add_coded(input int n);
    int   zeros;
    int   k;
    logic b;
    zeros = 0;
    k = track_bits.size() - 1;
    while (k >= 0 && track_bits[k] == 1'b0 && zeros < 4) begin
      zeros++;
      k--;
    end
    repeat (n) begin
      b = (zeros >= (gcr_now ? 2 : 3)) ? 1'b1 : 1'($urandom_range(0, 1));
      track_bits.push_back(b);
      zeros = b ? 0 : zeros + 1;
    end
  endtask

  task automatic add_sync_mark();
    if (gcr_now) begin
      add_bits('1, $urandom_range(10, 14));
    end else begin
      add_bits(32'(sync_now), 16);
    end
    add_bits(32'd0, 1);
  endtask

  task automatic build_track();
    int unsigned pick;
    int          segs;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      add_noise($urandom_range(1, 160));
    end else begin
      segs = (pick < 27) ? $urandom_range(21, 26) : $urandom_range(1, 4);
      add_noise($urandom_range(0, 20));
      for (int s = 0; s < segs; s++) begin
        repeat ($urandom_range(1, 3)) add_sync_mark();
        add_coded(segs > 8 ? $urandom_range(0, 24) : $urandom_range(0, 240));
        if (s < segs - 1 || $urandom_range(0, 2) != 0) begin
          add_bits(32'd0, gcr_now ? 3 : 4);
          add_noise($urandom_range(0, 14));
        end
      end
    end
  endtask

  task automatic send_track(input bit may_split);
    int          n;
    int          split;
    logic [7:0]  raw;
    while (track_bits.size() % 8 != 0 || track_bits.size() == 0) begin
      track_bits.push_back(1'($urandom_range(0, 1)));
    end
    n = track_bits.size() / 8;
    split = -1;
    if (may_split && n > 1 && $urandom_range(0, 11) == 0) begin
      split = $urandom_range(1, n - 1);
    end
    for (int b = 0; b < n; b++) begin
      if (b == split) begin
        wait_idle();
        write_reg(CFG_GCR_MODE, 16'(!gcr_now));
      end
      for (int k = 0; k < 8; k++) begin
        raw[7 - k] = track_bits[8 * b + k];
      end
      send_beat(raw, b == n - 1);
    end
    track_bits.delete();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset sync word: loss mid-track, then terminator
    add_bits(32'h448955AA, 32);
    add_bits(32'h00FF, 16);
    send_track(1'b0);
    // segment still open at track end
    add_bits(32'h448955AA, 32);
    add_bits(32'hAAAA, 16);
    send_track(1'b0);
    // loss in the last byte
    add_bits(32'h44895500, 32);
    send_track(1'b0);
    wait_idle();
    write_reg(CFG_GCR_MODE, 16'd1);
    add_bits(32'hFFE000, 24);
    send_track(1'b0);
    wait_idle();
    write_reg(CFG_GCR_MODE, 16'd0);
    write_reg(CFG_SYNC_WORD, 16'h0000);
    // every bit of the first byte matches, last match wins
    add_bits(32'h0000, 16);
    send_track(1'b0);
    wait_idle();
    write_reg(CFG_SYNC_WORD, 16'hFFFF);
    add_bits(32'hFFFF00, 24);
    send_track(1'b0);

    // fill the block while the receiver holds off
    wait_idle();
    pressure_asked++;
    repeat (12) send_beat(8'($urandom), 1'b1);

    while (items_sent < 790) begin
      if ($urandom_range(0, 4) == 0) begin
        wait_idle();
        pick_settings();
      end
      build_track();
      send_track(1'b1);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_floppy_sync_segment_finder passed");
    end else begin
      $display("tb_floppy_sync_segment_finder failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("tb_floppy_sync_segment_finder failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/fssf_pkg.sv
rtl/fssf_step.sv
rtl/floppy_sync_segment_finder.sv
rtl/fssf_checker.sv
bench/fssf_track_checker.sv
bench/tb_floppy_sync_segment_finder.sv
